[src/pair_event_table_core_defines.svh]
// ---------------------------------------------------------------------------
// Pair event table assertion macros
// Shorthand for the concurrent checks used in the table core.
// ---------------------------------------------------------------------------
`ifndef PAIR_EVENT_TABLE_CORE_DEFINES_SVH
`define PAIR_EVENT_TABLE_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PET_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PET_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

[src/pet_pkg.sv]
// ---------------------------------------------------------------------------
// Pair event table package
// Sizes, codes and request and response types shared by the table files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pet_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IndexBits  = 10;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned AddrBits   = $clog2(TableDepth);

  typedef logic signed [TimeBits-1:0] time_t;
  typedef logic [IndexBits-1:0]       index_t;

  localparam time_t TimeMax = {1'b0, {(TimeBits-1){1'b1}}};
  localparam time_t TimeMin = {1'b1, {(TimeBits-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_GET     = 3'd2,
    OP_SETKIND = 3'd3,
    OP_ADVANCE = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_KIND  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KIND_BINDING     = 3'd0,
    KIND_UNBINDING   = 3'd1,
    KIND_BOUND2BOUND = 3'd2,
    KIND_TRANS2TRANS = 3'd3,
    KIND_EMPTY       = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]            opcode;
    index_t                first_index;
    index_t                second_index;
    time_t                 wait_time;
    logic [7:0]            origin_state;
    logic [7:0]            end_state;
    logic [2:0]            event_kind;
    logic [TimeBits-2:0]   time_step;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    time_t       found_time;
    index_t      found_first;
    index_t      found_second;
    logic [7:0]  found_origin;
    logic [7:0]  found_end;
    logic [2:0]  found_kind;
  } rsp_t;

  typedef struct packed {
    index_t      first;
    index_t      second;
    time_t       wtime;
    logic [7:0]  origin;
    logic [7:0]  end_st;
    logic [2:0]  kind;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

endpackage

[src/pet_if.sv]
// ---------------------------------------------------------------------------
// Pair event table channels
// Valid/ready request and response channels of the table core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pet_req_if;
  logic          valid;
  logic          ready;
  pet_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pet_rsp_if;
  logic          valid;
  logic          ready;
  pet_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/pet_ram.sv]
// ---------------------------------------------------------------------------
// Pair event table RAM
// Simple dual-port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pet_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[src/pair_event_table_core.sv]
// ---------------------------------------------------------------------------
// Pair event table core
// Table of pending events keyed by a particle pair, held in one RAM.
// ---------------------------------------------------------------------------
//  channel  direction  payload
//  req_i    in         opcode, pair key, wait time, states, kind, time step
//  rsp_o    out        status and the entry found by get
//
//  Remove, get, advance, and add or set kind with a valid kind scan all
//  TableDepth entries, one RAM read per cycle. The response is loaded in the
//  apply state; the next request can be taken in the cycle after that. Add or
//  set kind with a bad kind and unused opcodes skip the scan. Advance writes
//  each valid entry back as its read data returns. Reset clears the valid
//  bits and the control state at once. A stalled response holds the last step
//  and blocks the next request.
`timescale 1ns / 1ps
`include "pair_event_table_core_defines.svh"

module pair_event_table_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  pet_req_if.sink         req_i,
  pet_rsp_if.source       rsp_o
);

  localparam int unsigned AB = pet_pkg::AddrBits;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [AB:0]             cnt_q, cnt_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [AB-1:0]           chk_addr_q, chk_addr_d;
  logic                    hit_q, hit_d;
  logic [AB-1:0]           hit_idx_q, hit_idx_d;
  pet_pkg::entry_t         hit_data_q, hit_data_d;
  logic                    free_q, free_d;
  logic [AB-1:0]           free_idx_q, free_idx_d;
  logic [pet_pkg::TableDepth-1:0] valid_q, valid_d;
  pet_pkg::req_t           req_q, req_d;
  logic                    rsp_valid_q, rsp_valid_d;
  pet_pkg::rsp_t           rsp_data_q, rsp_data_d;

  logic                    ram_we, ram_re;
  logic [AB-1:0]           ram_waddr, ram_raddr;
  pet_pkg::entry_t         ram_wdata, ram_rdata;
  logic [pet_pkg::EntryBits-1:0] ram_rdata_raw;

  logic                    req_fire, issue, out_free, kind_bad, needs_scan;
  logic                    cur_valid, key_match;
  logic signed [pet_pkg::TimeBits:0] adv_diff;
  pet_pkg::time_t          adv_time;
  pet_pkg::entry_t         new_entry, adv_entry, kind_entry;
  pet_pkg::rsp_t           res;

  pet_ram #(
    .Width (pet_pkg::EntryBits),
    .Depth (pet_pkg::TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = pet_pkg::entry_t'(ram_rdata_raw);

  assign req_i.ready   = (state_q == S_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_data_q;
  assign out_free      = !rsp_valid_q || rsp_o.ready;

  assign issue     = (state_q == S_SCAN) && (cnt_q < (AB + 1)'(pet_pkg::TableDepth));
  assign cur_valid = valid_q[chk_addr_q];
  assign key_match = (ram_rdata.first == req_q.first_index) &&
                     (ram_rdata.second == req_q.second_index);
  assign kind_bad  = (req_q.event_kind > pet_pkg::KIND_EMPTY);

  always_comb begin
    unique case (req_i.payload.opcode)
      pet_pkg::OP_ADD, pet_pkg::OP_SETKIND:
        needs_scan = !(req_i.payload.event_kind > pet_pkg::KIND_EMPTY);
      pet_pkg::OP_REMOVE, pet_pkg::OP_GET, pet_pkg::OP_ADVANCE:
        needs_scan = 1'b1;
      default:
        needs_scan = 1'b0;
    endcase
  end

  // Saturating subtraction of the time step from a valid entry.
  assign adv_diff = {ram_rdata.wtime[pet_pkg::TimeBits-1], ram_rdata.wtime} -
                    $signed({2'b00, req_q.time_step});
  assign adv_time = (adv_diff[pet_pkg::TimeBits] != adv_diff[pet_pkg::TimeBits-1]) ?
                    pet_pkg::TimeMin : adv_diff[pet_pkg::TimeBits-1:0];

  always_comb begin
    adv_entry       = ram_rdata;
    adv_entry.wtime = adv_time;
    kind_entry      = hit_data_q;
    kind_entry.kind = req_q.event_kind;
    new_entry.first  = req_q.first_index;
    new_entry.second = req_q.second_index;
    new_entry.wtime  = req_q.wait_time;
    new_entry.origin = req_q.origin_state;
    new_entry.end_st = req_q.end_state;
    new_entry.kind   = req_q.event_kind;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    chk_vld_d   = issue;
    chk_addr_d  = cnt_q[AB-1:0];
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_data_d  = hit_data_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    valid_d     = valid_q;
    req_d       = req_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_data_d  = rsp_data_q;
    ram_re      = issue;
    ram_raddr   = cnt_q[AB-1:0];
    ram_we      = 1'b0;
    ram_waddr   = chk_addr_q;
    ram_wdata   = adv_entry;

    res = '0;
    res.status = pet_pkg::ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          req_d  = req_i.payload;
          cnt_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          state_d = needs_scan ? S_SCAN : S_APPLY;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (chk_vld_q) begin
          if (cur_valid && key_match && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = chk_addr_q;
            hit_data_d = ram_rdata;
          end
          if (!cur_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_addr_q;
          end
          if (cur_valid && (req_q.opcode == pet_pkg::OP_ADVANCE)) begin
            ram_we = 1'b1;
          end
          if (chk_addr_q == AB'(pet_pkg::TableDepth - 1)) begin
            state_d = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        unique case (req_q.opcode)
          pet_pkg::OP_ADD: begin
            if (kind_bad) begin
              res.status = pet_pkg::ST_BAD_KIND;
            end else if (hit_q) begin
              if ($signed(hit_data_q.wtime) > $signed(req_q.wait_time)) begin
                ram_we    = out_free;
                ram_waddr = hit_idx_q;
                ram_wdata = new_entry;
              end
            end else if (free_q) begin
              ram_we    = out_free;
              ram_waddr = free_idx_q;
              ram_wdata = new_entry;
              if (out_free) begin
                valid_d[free_idx_q] = 1'b1;
              end
            end else begin
              res.status = pet_pkg::ST_FULL;
            end
          end
          pet_pkg::OP_REMOVE: begin
            if (hit_q) begin
              if (out_free) begin
                valid_d[hit_idx_q] = 1'b0;
              end
            end else begin
              res.status = pet_pkg::ST_NOT_FOUND;
            end
          end
          pet_pkg::OP_GET: begin
            if (hit_q) begin
              res.found_time   = hit_data_q.wtime;
              res.found_first  = hit_data_q.first;
              res.found_second = hit_data_q.second;
              res.found_origin = hit_data_q.origin;
              res.found_end    = hit_data_q.end_st;
              res.found_kind   = hit_data_q.kind;
            end else begin
              res.status     = pet_pkg::ST_NOT_FOUND;
              res.found_time = pet_pkg::TimeMax;
            end
          end
          pet_pkg::OP_SETKIND: begin
            if (kind_bad) begin
              res.status = pet_pkg::ST_BAD_KIND;
            end else if (hit_q) begin
              ram_we    = out_free;
              ram_waddr = hit_idx_q;
              ram_wdata = kind_entry;
            end else begin
              res.status = pet_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = res;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      valid_q     <= valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= chk_addr_d;
    hit_idx_q  <= hit_idx_d;
    hit_data_q <= hit_data_d;
    free_idx_q <= free_idx_d;
    req_q      <= req_d;
    rsp_data_q <= rsp_data_d;
  end

  `PET_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_i.ready,
                   "Request channel stayed ready after an accepted request.")
  `PET_ASSERT_SAME(a_scan_write_advance, ram_we && (state_q == S_SCAN),
                   req_q.opcode == pet_pkg::OP_ADVANCE,
                   "Entry written during a scan that is not an advance.")
  `PET_ASSERT_SAME(a_hit_key, hit_q && (state_q == S_APPLY),
                   (hit_data_q.first == req_q.first_index) &&
                   (hit_data_q.second == req_q.second_index),
                   "Captured entry key differs from the request key.")
  `PET_ASSERT_SAME(a_free_slot, free_q && (state_q == S_APPLY),
                   !valid_q[free_idx_q],
                   "Recorded free slot holds a valid entry.")

endmodule
